FILE: rtl/pchl_pkg.sv
// Package for the palette code hash lookup block.
// Holds sizes, command and status codes, the slot entry type and helper functions.
// No dependencies.
package pchl_pkg;

    localparam int MAX_CODE_BYTES = 4;
    localparam int MAX_ENTRIES    = 256;
    localparam int MAX_SLOTS      = 512;
    localparam int MIN_SLOT_LOG   = 4;

    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CODE_W    = 32;
    localparam int COLOR_W   = 32;
    localparam int ENTRY_W   = $clog2(MAX_ENTRIES);
    localparam int COUNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int BI_W      = (MAX_CODE_BYTES > 1) ? $clog2(MAX_CODE_BYTES) : 1;
    localparam int CB_W      = 3;
    localparam int CC_W      = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CODE_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 2'd1;

    typedef struct packed {
        logic               valid;
        logic [ENTRY_W-1:0] entry;
    } t_slot;

    // Index of the last code byte that is hashed and compared.
    function automatic logic [BI_W-1:0] last_byte(input logic [CB_W-1:0] cb);
        logic [BI_W-1:0] r;
        if (cb == '0) begin
            r = '0;
        end else if (cb >= CB_W'(MAX_CODE_BYTES)) begin
            r = BI_W'(MAX_CODE_BYTES - 1);
        end else begin
            r = BI_W'(cb - 1'b1);
        end
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] byte_mask(input logic [BI_W-1:0] last);
        logic [CODE_W-1:0] m;
        m = '0;
        for (int b = 0; b < MAX_CODE_BYTES; b++) begin
            if (BI_W'(b) <= last) begin
                m[8*b +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    function automatic logic [COUNT_W-1:0] entry_limit(input logic [CC_W-1:0] cc);
        logic [COUNT_W-1:0] r;
        if (cc > CC_W'(MAX_ENTRIES)) begin
            r = COUNT_W'(MAX_ENTRIES);
        end else begin
            r = COUNT_W'(cc);
        end
        return r;
    endfunction

    // Slot mask: each bit above the minimum table size is set when twice the
    // palette size exceeds the table size that bit would otherwise cap.
    function automatic logic [SLOT_W-1:0] slot_mask(input logic [COUNT_W-1:0] lim);
        logic [COUNT_W:0]  need;
        logic [SLOT_W-1:0] m;
        need = {lim, 1'b0};
        m    = '0;
        for (int j = 0; j < SLOT_W; j++) begin
            if (j < MIN_SLOT_LOG) begin
                m[j] = 1'b1;
            end else begin
                m[j] = (need > (COUNT_W+1)'(64'd1 << j));
            end
        end
        return m;
    endfunction

endpackage

FILE: rtl/pchl_if.sv
// Valid/ready channel interfaces for the palette code hash lookup block.
// Depends on pchl_pkg for field widths.
interface pchl_in_if import pchl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] color_in;

    modport source(output valid, output cmd, output code, output color_in, input ready);
    modport sink(input valid, input cmd, input code, input color_in, output ready);
endinterface

interface pchl_out_if import pchl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COLOR_W-1:0]  color_out;
    logic                transparent;

    modport source(output valid, output status, output color_out, output transparent,
                   input ready);
    modport sink(input valid, input status, input color_out, input transparent,
                 output ready);
endinterface

FILE: rtl/palette_code_hash_lookup_top.sv
// Top level of the palette code hash lookup block: FNV-1a hashing and a linear
// probe over an open-addressing slot table. Depends on pchl_pkg and pchl_if.sv.
//
// One transaction at a time runs through a small sequencer around one shared
// 32x32 multiplier and the slot, code and color memories. An insert or lookup
// hashes the code, one multiply a cycle, then for each slot it reaches reads the
// slot (probe, slot states) and, if it is occupied, compares the stored code
// (code state); a response state posts the result. An insert into a full
// palette and the unused command go from idle straight to the response state.
// A clear sweeps all 512 slots, one per cycle, then posts its result. After
// reset the same sweep runs before the first transaction is accepted;
// configuration writes are taken throughout. A finished result sits in an output
// register, so the next transaction can be accepted while it waits to be taken.
module palette_code_hash_lookup_top import pchl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pchl_in_if.sink               i_in,
    pchl_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_SLOT  = 3'd4;
    localparam logic [2:0] S_CODE  = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    // Memories.
    t_slot              slot_mem  [MAX_SLOTS];
    logic [CODE_W-1:0]  code_mem  [MAX_ENTRIES];
    logic [COLOR_W-1:0] color_mem [MAX_ENTRIES];
    t_slot              r_slot_q;
    logic [CODE_W-1:0]  r_code_q;
    logic [COLOR_W-1:0] r_color_q;

    // Configuration.
    logic [CB_W-1:0] r_code_bytes;
    logic [CC_W-1:0] r_color_count;

    // Sequencer and working registers.
    logic [2:0]          r_state,      n_state;
    logic [SLOT_W-1:0]   r_clr,        n_clr;
    logic                r_clr_resp,   n_clr_resp;
    logic [CMD_W-1:0]    r_cmd,        n_cmd;
    logic [CODE_W-1:0]   r_code,       n_code;
    logic [COLOR_W-1:0]  r_color,      n_color;
    logic [CODE_W-1:0]   r_cmask,      n_cmask;
    logic [BI_W-1:0]     r_last,       n_last;
    logic [BI_W-1:0]     r_bi,         n_bi;
    logic [31:0]         r_hash,       n_hash;
    logic [SLOT_W-1:0]   r_mask,       n_mask;
    logic [SLOT_W-1:0]   r_idx,        n_idx;
    logic [SLOT_W-1:0]   r_k,          n_k;
    logic [COUNT_W-1:0]  r_count,      n_count;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [COLOR_W-1:0]  r_res_color,  n_res_color;
    logic                r_out_valid,  n_out_valid;
    logic [STATUS_W-1:0] r_status,     n_status;
    logic [COLOR_W-1:0]  r_color_out,  n_color_out;
    logic                r_transp,     n_transp;

    logic               w_accept;
    logic [31:0]        w_prod;
    logic               w_match;
    logic               w_slot_we;
    logic [SLOT_W-1:0]  w_slot_waddr;
    t_slot              w_slot_wdata;
    logic               w_entry_we;
    logic [COUNT_W-1:0] w_limit;

    assign i_in.ready        = (r_state == S_IDLE);
    assign w_accept          = i_in.valid && i_in.ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.color_out   = r_color_out;
    assign o_out.transparent = r_transp;

    assign w_limit = entry_limit(r_color_count);
    assign w_prod  = (r_hash ^ {24'd0, r_code[{r_bi, 3'b000} +: 8]}) * FNV_PRIME;
    assign w_match = ((r_code_q ^ r_code) & r_cmask) == '0;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_clr_resp   = r_clr_resp;
        n_cmd        = r_cmd;
        n_code       = r_code;
        n_color      = r_color;
        n_cmask      = r_cmask;
        n_last       = r_last;
        n_bi         = r_bi;
        n_hash       = r_hash;
        n_mask       = r_mask;
        n_idx        = r_idx;
        n_k          = r_k;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_color  = r_res_color;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        n_color_out  = r_color_out;
        n_transp     = r_transp;
        w_slot_we    = 1'b0;
        w_slot_waddr = r_idx;
        w_slot_wdata = '{valid: 1'b1, entry: r_count[ENTRY_W-1:0]};
        w_entry_we   = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd        = i_in.cmd;
                    n_code       = i_in.code;
                    n_color      = i_in.color_in;
                    n_last       = last_byte(r_code_bytes);
                    n_cmask      = byte_mask(last_byte(r_code_bytes));
                    n_mask       = slot_mask(w_limit);
                    n_bi         = '0;
                    n_k          = '0;
                    n_hash       = FNV_BASIS;
                    n_res_status = ST_OK;
                    n_res_color  = '0;
                    priority if (i_in.cmd == CMD_CLEAR) begin
                        n_clr      = '0;
                        n_clr_resp = 1'b1;
                        n_state    = S_CLEAR;
                    end else if (i_in.cmd == CMD_INSERT && r_count >= w_limit) begin
                        n_res_status = ST_FULL;
                        n_state      = S_RESP;
                    end else if (i_in.cmd == CMD_INSERT || i_in.cmd == CMD_LOOKUP) begin
                        n_state = S_HASH;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_CLEAR: begin
                w_slot_we    = 1'b1;
                w_slot_waddr = r_clr;
                w_slot_wdata = '0;
                n_clr        = r_clr + 1'b1;
                if (r_clr == SLOT_W'(MAX_SLOTS - 1)) begin
                    n_count = '0;
                    n_state = r_clr_resp ? S_RESP : S_IDLE;
                end
            end
            S_HASH: begin
                n_hash = w_prod;
                n_bi   = r_bi + 1'b1;
                if (r_bi == r_last) begin
                    n_idx   = w_prod[SLOT_W-1:0] & r_mask;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                n_state = S_SLOT;
            end
            S_SLOT: begin
                if (!r_slot_q.valid) begin
                    // Empty slot ends the probe.
                    if (r_cmd == CMD_INSERT) begin
                        w_slot_we  = 1'b1;
                        w_entry_we = 1'b1;
                        n_count    = r_count + 1'b1;
                    end else begin
                        n_res_status = ST_NOTFOUND;
                    end
                    n_state = S_RESP;
                end else begin
                    n_state = S_CODE;
                end
            end
            S_CODE: begin
                if (w_match) begin
                    if (r_cmd == CMD_INSERT) begin
                        // Redefined code: repoint the slot to the new entry.
                        w_slot_we  = 1'b1;
                        w_entry_we = 1'b1;
                        n_count    = r_count + 1'b1;
                    end else begin
                        n_res_color = r_color_q;
                    end
                    n_state = S_RESP;
                end else if (r_k == r_mask) begin
                    n_res_status = (r_cmd == CMD_INSERT) ? ST_FULL : ST_NOTFOUND;
                    n_state      = S_RESP;
                end else begin
                    n_idx   = (r_idx + 1'b1) & r_mask;
                    n_k     = r_k + 1'b1;
                    n_state = S_PROBE;
                end
            end
            S_RESP: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_color_out = r_res_color;
                    n_transp    = (r_cmd == CMD_LOOKUP) && (r_res_status == ST_OK)
                                  && (r_res_color[31:24] == 8'd0);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_clr_resp    <= 1'b0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
            r_code_bytes  <= CB_W'(1);
            r_color_count <= CC_W'(MAX_ENTRIES);
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_clr_resp  <= n_clr_resp;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_idx == REG_CODE_BYTES) begin
                r_code_bytes <= i_cfg_data[CB_W-1:0];
            end
            if (i_cfg_we && i_cfg_idx == REG_COLOR_COUNT) begin
                r_color_count <= i_cfg_data[CC_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_code       <= n_code;
        r_color      <= n_color;
        r_cmask      <= n_cmask;
        r_last       <= n_last;
        r_bi         <= n_bi;
        r_hash       <= n_hash;
        r_mask       <= n_mask;
        r_idx        <= n_idx;
        r_k          <= n_k;
        r_res_status <= n_res_status;
        r_res_color  <= n_res_color;
        r_status     <= n_status;
        r_color_out  <= n_color_out;
        r_transp     <= n_transp;
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            slot_mem[w_slot_waddr] <= w_slot_wdata;
        end
        r_slot_q <= slot_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_entry_we) begin
            code_mem[r_count[ENTRY_W-1:0]]  <= r_code;
            color_mem[r_count[ENTRY_W-1:0]] <= r_color;
        end
        r_code_q  <= code_mem[r_slot_q.entry];
        r_color_q <= color_mem[r_slot_q.entry];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(MAX_ENTRIES))
        else $error("entry count beyond palette capacity");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_entry_we |=> (r_count == $past(r_count) + 1'b1))
        else $error("entry write did not advance the entry count");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> ((r_idx & ~r_mask) == '0))
        else $error("probe index outside the slot table");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RESP))
        else $error("result posted outside the response state");

endmodule

FILE: tb/sv/tb_palette_code_hash_lookup_top.sv
// Self-checking testbench for palette_code_hash_lookup_top: directed and random palette
// traffic, checked against an in-bench model of the FNV-1a hash table.
// Depends on pchl_pkg and the channel interfaces in pchl_if.sv.
module tb_palette_code_hash_lookup_top;
    import pchl_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 3000;
    localparam int REPORT_LINES = 100;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COLOR_W-1:0]  color;
        logic                transparent;
    } t_palette_answer;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pchl_in_if  in_bus();
    pchl_out_if out_bus();

    palette_code_hash_lookup_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Model of the palette: registers, entry stores and slot table.
    logic [CB_W-1:0]    cfg_bytes = 3'd1;
    logic [CC_W-1:0]    cfg_count = 9'd256;
    logic [CODE_W-1:0]  code_mem  [MAX_ENTRIES];
    logic [COLOR_W-1:0] color_mem [MAX_ENTRIES];
    int unsigned        slot_ref  [MAX_SLOTS] = '{default: 0};  // 0 empty, else entry + 1
    int unsigned        n_entries = 0;

    t_palette_answer   pending_answers[$];
    logic [CODE_W-1:0] inserted_codes[$];
    int unsigned       mismatch_count = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       hold_cycles = 0;
    bit                idle_on = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned bytes_used();
        if (cfg_bytes == 0) return 1;
        if (cfg_bytes > MAX_CODE_BYTES) return MAX_CODE_BYTES;
        return 32'(cfg_bytes);
    endfunction

    function automatic int unsigned palette_limit();
        if (cfg_count > MAX_ENTRIES) return MAX_ENTRIES;
        return 32'(cfg_count);
    endfunction

    function automatic int unsigned table_size();
        int unsigned s;
        s = 16;
        while (s < 2 * palette_limit() && s < MAX_SLOTS) s = s * 2;
        return s;
    endfunction

    function automatic logic [CODE_W-1:0] significant_mask(input int unsigned nbytes);
        if (nbytes >= 4) return '1;
        return (32'h1 << (8 * nbytes)) - 32'h1;
    endfunction

    function automatic logic [31:0] fnv_hash(input logic [CODE_W-1:0] code,
                                             input int unsigned nbytes);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < nbytes; i++) begin
            h = (h ^ {24'h0, code[8*i +: 8]}) * FNV_PRIME;
        end
        return h;
    endfunction

    // Linear probe from the home slot for the matching code or the first empty slot.
    // Gives up after one lap of the table.
    function automatic bit probe_slot(input logic [CODE_W-1:0] code, output int unsigned where);
        int unsigned n;
        int unsigned idx;
        logic [CODE_W-1:0] m;
        n = table_size();
        m = significant_mask(bytes_used());
        idx = fnv_hash(code, bytes_used()) & (n - 1);
        where = 0;
        for (int k = 0; k < n; k++) begin
            if (slot_ref[idx] == 0 || (code_mem[slot_ref[idx] - 1] & m) == (code & m)) begin
                where = idx;
                return 1'b1;
            end
            idx = (idx + 1) & (n - 1);
        end
        return 1'b0;
    endfunction

    function automatic t_palette_answer predict_palette(input logic [CMD_W-1:0] cmd,
                                                        input logic [CODE_W-1:0] code,
                                                        input logic [COLOR_W-1:0] color);
        t_palette_answer r;
        int unsigned where;
        r = '{status: ST_OK, color: '0, transparent: 1'b0};
        case (cmd)
            CMD_INSERT: begin
                if (n_entries >= palette_limit() || !probe_slot(code, where)) begin
                    r.status = ST_FULL;
                end else begin
                    code_mem[n_entries]  = code;
                    color_mem[n_entries] = color;
                    slot_ref[where]      = n_entries + 1;
                    n_entries++;
                end
            end
            CMD_LOOKUP: begin
                if (probe_slot(code, where) && slot_ref[where] != 0) begin
                    r.color       = color_mem[slot_ref[where] - 1];
                    r.transparent = (r.color[31:24] == 8'h00);
                end else begin
                    r.status = ST_NOTFOUND;
                end
            end
            CMD_CLEAR: begin
                foreach (slot_ref[i]) slot_ref[i] = 0;
                n_entries = 0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES) begin
            $display("ERROR at %0t: %s expected %h got %h", $time, what, want, got);
        end
    endtask

    // Offers one transaction, after a random gap while idle_on is set. Valid is left high on return so that
    // a following transaction without a gap keeps it asserted.
    task automatic send_palette_op(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                                   input logic [COLOR_W-1:0] color);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid    <= 1'b1;
        in_bus.cmd      <= cmd;
        in_bus.code     <= code;
        in_bus.color_in <= color;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        pending_answers.push_back(predict_palette(cmd, code, color));
    endtask

    task automatic wait_results_done();
        in_bus.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [CB_W-1:0] cb, input logic [CC_W-1:0] cc);
        wait_results_done();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_CODE_BYTES;
        i_cfg_data <= CFG_DATA_W'(cb);
        @(posedge i_clk);
        i_cfg_idx  <= REG_COLOR_COUNT;
        i_cfg_data <= CFG_DATA_W'(cc);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        cfg_bytes = cb;
        cfg_count = cc;
    endtask

    // Mostly inserts and lookups, the lookups mostly of codes already inserted, with some misses,
    // redefinitions, clears and the unused command mixed in.
    task automatic send_random_op();
        int unsigned pick;
        logic [CODE_W-1:0]  code;
        logic [CODE_W-1:0]  m;
        logic [COLOR_W-1:0] color;
        pick  = $urandom_range(0, 99);
        code  = $urandom();
        color = $urandom();
        m     = significant_mask(bytes_used());
        if ($urandom_range(0, 4) == 0) color[31:24] = 8'h00;
        if (pick < 44) begin
            if (inserted_codes.size() > 0 && $urandom_range(0, 3) == 0) begin
                code = inserted_codes[$urandom_range(0, inserted_codes.size() - 1)];
            end
            if (inserted_codes.size() < 300) inserted_codes.push_back(code);
            send_palette_op(CMD_INSERT, code, color);
        end else if (pick < 94) begin
            if (inserted_codes.size() > 0 && pick < 82) begin
                code = (inserted_codes[$urandom_range(0, inserted_codes.size() - 1)] & m)
                     | (code & ~m);
            end
            send_palette_op(CMD_LOOKUP, code, color);
        end else if (pick < 97) begin
            inserted_codes.delete();
            send_palette_op(CMD_CLEAR, code, color);
        end else begin
            send_palette_op(CMD_UNUSED, code, color);
        end
    endtask

    task automatic test_directed_cases();
        apply_config(3'd4, 9'd256);
        send_palette_op(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_palette_op(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_palette_op(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_palette_op(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_palette_op(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        // Defining a code again points its slot at the newer colour.
        send_palette_op(CMD_INSERT, 32'h0000_0000, 32'h80FF_00FF);
        send_palette_op(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_palette_op(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_palette_op(CMD_LOOKUP, 32'h00FF_FFFF, 32'h0000_0000);
        send_palette_op(CMD_CLEAR,  32'h0000_0000, 32'h0000_0000);
        send_palette_op(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        // A byte count of zero acts as one, so the upper code bytes are ignored.
        apply_config(3'd0, 9'd2);
        send_palette_op(CMD_INSERT, 32'h1111_1100, 32'h4433_2211);
        send_palette_op(CMD_LOOKUP, 32'hAAAA_AA00, 32'h0000_0000);
        send_palette_op(CMD_INSERT, 32'h0000_0022, 32'h00C0_FFEE);
        send_palette_op(CMD_INSERT, 32'h0000_0033, 32'h5555_5555);
        send_palette_op(CMD_INSERT, 32'h0000_0000, 32'h6666_6666);
        // A byte count above the maximum saturates; a palette size of zero takes nothing.
        apply_config(3'd7, 9'd0);
        send_palette_op(CMD_INSERT, 32'h0000_0044, 32'h7777_7777);
        send_palette_op(CMD_LOOKUP, 32'h1111_1100, 32'h0000_0000);
        send_palette_op(CMD_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        apply_config(3'd5, 9'd511);
        send_palette_op(CMD_INSERT, 32'h1234_5678, 32'h00AB_CDEF);
        send_palette_op(CMD_LOOKUP, 32'h1234_5678, 32'h0000_0000);
        send_palette_op(CMD_LOOKUP, 32'h0234_5678, 32'h0000_0000);
        send_palette_op(CMD_CLEAR,  32'h0000_0000, 32'h0000_0000);
        wait_results_done();
    endtask

    // Fill the first sixteen slots of a 32-slot table, then shrink the table to those sixteen
    // and look up codes, some not there, so the probe has to run a full lap and give up.
    task automatic test_stale_slots();
        logic [CODE_W-1:0] homed[$];
        logic [CODE_W-1:0] c;
        apply_config(3'd1, 9'd16);
        send_palette_op(CMD_CLEAR, 32'h0, 32'h0);
        for (int b = 0; b < 16; b++) begin
            for (int v = 0; v < 256; v++) begin
                c = CODE_W'(v);
                if ((fnv_hash(c, 1) & 32'd31) == b) begin
                    homed.push_back(c);
                    send_palette_op(CMD_INSERT, c, $urandom());
                    break;
                end
            end
        end
        apply_config(3'd1, 9'd1);
        foreach (homed[i]) send_palette_op(CMD_LOOKUP, homed[i] ^ ($urandom() & 32'hFFFF_FF00),
                                           32'h0);
        repeat (12) send_palette_op(CMD_LOOKUP, $urandom(), $urandom());
        repeat (2) send_palette_op(CMD_INSERT, $urandom(), $urandom());
        apply_config(3'd2, 9'd1);
        foreach (homed[i]) send_palette_op(CMD_LOOKUP, homed[i], 32'h0);
        send_palette_op(CMD_CLEAR, 32'h0, 32'h0);
        wait_results_done();
    endtask

    task automatic test_flow_control();
        apply_config(3'd2, 9'd64);
        inserted_codes.delete();
        send_palette_op(CMD_CLEAR, 32'h0, 32'h0);
        // The receiver stops for a long stretch while transactions keep coming.
        idle_on = 1'b0;
        hold_cycles = 200;
        repeat (30) send_random_op();
        idle_on = 1'b1;
        repeat (10) send_random_op();
        wait_results_done();
        repeat (10) send_random_op();
        wait_results_done();
    endtask

    task automatic test_random_traffic(input int unsigned phases, input int unsigned per_phase);
        logic [CB_W-1:0] cb;
        logic [CC_W-1:0] cc;
        for (int p = 0; p < phases; p++) begin
            cb = (p < 8) ? CB_W'(p) : CB_W'($urandom_range(0, 7));
            case ($urandom_range(0, 5))
                0:       cc = 9'd1;
                1:       cc = 9'd256;
                2:       cc = 9'd511;
                3:       cc = CC_W'($urandom_range(2, 16));
                default: cc = CC_W'($urandom_range(0, 511));
            endcase
            apply_config(cb, cc);
            // Sometimes the old entries stay in place under the new settings.
            if ($urandom_range(0, 3) != 0) begin
                inserted_codes.delete();
                send_palette_op(CMD_CLEAR, $urandom(), $urandom());
            end
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (per_phase) send_random_op();
        end
        idle_on = 1'b1;
        wait_results_done();
    endtask

    initial begin
        int unsigned stall;
        out_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 14) : 0;
            if (hold_cycles > 0) begin
                stall = stall + hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (out_bus.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        t_palette_answer want;
        if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("answer with no transaction pending", '0, out_bus.color_out);
            end else begin
                want = pending_answers.pop_front();
                if (out_bus.status !== want.status) begin
                    report_mismatch("status", 32'(want.status), 32'(out_bus.status));
                end
                if (out_bus.color_out !== want.color) begin
                    report_mismatch("color_out", want.color, out_bus.color_out);
                end
                if (out_bus.transparent !== want.transparent) begin
                    report_mismatch("transparent", 32'(want.transparent),
                                    32'(out_bus.transparent));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
            (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_CODE_BYTES;
        i_cfg_data      <= '0;
        in_bus.valid    <= 1'b0;
        in_bus.cmd      <= CMD_INSERT;
        in_bus.code     <= '0;
        in_bus.color_in <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_stale_slots();
        test_flow_control();
        test_random_traffic(17, 70);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: palette_code_hash_lookup_top.f
rtl/pchl_pkg.sv
rtl/pchl_if.sv
rtl/palette_code_hash_lookup_top.sv
tb/sv/tb_palette_code_hash_lookup_top.sv
